[src/psl_pkg.sv]
// Package for the per-source connection limiter.
// Holds table sizes, field widths, status codes, controller states and the
// command and status structs between controller and datapath. No dependencies.
package psl_pkg;

  // Table depth and derived widths.
  localparam int MAX_CONN = 64;
  localparam int IDX_W    = (MAX_CONN > 1) ? $clog2(MAX_CONN) : 1;
  localparam int CNT_W    = 7;

  // Field widths fixed by the interface.
  localparam int ADDR_W   = 64;
  localparam int HANDLE_W = 16;
  localparam int STAT_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Table entry layouts.
  localparam int SRC_W  = 2 * ADDR_W + CNT_W;
  localparam int CONN_W = HANDLE_W + 2 * ADDR_W;

  // Reset values of the limit registers.
  localparam logic [CNT_W-1:0] MAX_TOTAL_RST   = CNT_W'(40);
  localparam logic [CNT_W-1:0] MAX_PER_SRC_RST = CNT_W'(40);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_SRC = CFG_IDX_W'(1);

  // Request codes.
  localparam logic FUNC_OPEN  = 1'b0;
  localparam logic FUNC_CLOSE = 1'b1;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_ALLOW     = 3'd0,
    ST_DENY_SRC  = 3'd1,
    ST_DENY_FULL = 3'd2,
    ST_CLOSED    = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SRC_RD,
    S_SRC_CMP,
    S_OPEN_DECIDE,
    S_CONN_RD,
    S_CONN_CMP,
    S_CONN_LAST_RD,
    S_CONN_MOVE,
    S_CLOSE_SRC,
    S_SRC_LAST_RD,
    S_SRC_MOVE,
    S_RESULT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic    load;
    logic    idx_clr;
    logic    idx_inc;
    logic    src_rd_last;
    logic    conn_rd_last;
    logic    src_hit;
    logic    conn_hit;
    logic    open_allow;
    logic    total_dec;
    logic    conn_move;
    logic    src_dec;
    logic    src_move;
    logic    set_code;
    status_t code;
    logic    res_load;
  } cmd_t;

  // Status from datapath to controller. req_func is the request code on the
  // input ports; func is the code of the request being worked on.
  typedef struct packed {
    logic req_func;
    logic func;
    logic src_end;
    logic src_match;
    logic conn_end;
    logic conn_match;
    logic full;
    logic per_src;
    logic src_found;
    logic last_conn_of_src;
  } stat_t;

endpackage

[src/psl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the connection and source tables. No dependencies.
module psl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/psl_ctrl.sv]
// Controller of the per-source connection limiter: sequences the table
// searches and updates. Depends on psl_pkg.
module psl_ctrl
  import psl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.code  = ST_ALLOW;
    unique case (state_r)
      // The request is branched on as it arrives, before it is latched.
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (st.req_func == FUNC_CLOSE) ? S_CONN_RD : S_SRC_RD;
        end
      end
      // The read address is the scan index; the registered read data is compared in S_SRC_CMP.
      S_SRC_RD: begin
        if (st.src_end) begin
          state_nxt = (st.func == FUNC_CLOSE) ? S_CLOSE_SRC : S_OPEN_DECIDE;
        end else begin
          state_nxt = S_SRC_CMP;
        end
      end
      S_SRC_CMP: begin
        if (st.src_match) begin
          cmd.src_hit = 1'b1;
          state_nxt   = (st.func == FUNC_CLOSE) ? S_CLOSE_SRC : S_OPEN_DECIDE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SRC_RD;
        end
      end
      // The full check takes priority over the per-source check.
      S_OPEN_DECIDE: begin
        cmd.set_code = 1'b1;
        if (st.full) begin
          cmd.code = ST_DENY_FULL;
        end else if (st.per_src) begin
          cmd.code = ST_DENY_SRC;
        end else begin
          cmd.code       = ST_ALLOW;
          cmd.open_allow = 1'b1;
        end
        state_nxt = S_RESULT;
      end
      S_CONN_RD: begin
        if (st.conn_end) begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_UNKNOWN;
          state_nxt    = S_RESULT;
        end else begin
          state_nxt = S_CONN_CMP;
        end
      end
      S_CONN_CMP: begin
        if (st.conn_match) begin
          cmd.conn_hit = 1'b1;
          state_nxt    = S_CONN_LAST_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_CONN_RD;
        end
      end
      S_CONN_LAST_RD: begin
        cmd.conn_rd_last = 1'b1;
        state_nxt        = S_CONN_MOVE;
      end
      // Last connection moves into the freed slot; then find its source.
      S_CONN_MOVE: begin
        cmd.conn_move = 1'b1;
        cmd.total_dec = 1'b1;
        cmd.idx_clr   = 1'b1;
        state_nxt     = S_SRC_RD;
      end
      S_CLOSE_SRC: begin
        cmd.code = ST_CLOSED;
        if (st.src_found) begin
          cmd.src_dec = 1'b1;
          if (st.last_conn_of_src) begin
            state_nxt = S_SRC_LAST_RD;
          end else begin
            cmd.set_code = 1'b1;
            state_nxt    = S_RESULT;
          end
        end else begin
          cmd.set_code = 1'b1;
          state_nxt    = S_RESULT;
        end
      end
      S_SRC_LAST_RD: begin
        cmd.src_rd_last = 1'b1;
        state_nxt       = S_SRC_MOVE;
      end
      S_SRC_MOVE: begin
        cmd.src_move = 1'b1;
        cmd.set_code = 1'b1;
        cmd.code     = ST_CLOSED;
        state_nxt    = S_RESULT;
      end
      S_RESULT: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[src/psl_dp.sv]
// Datapath of the per-source connection limiter: limit registers, counters,
// the two tables, comparators and result registers. Depends on psl_pkg, psl_ram.
module psl_dp
  import psl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_func,
  input  logic [ADDR_W-1:0]     in_source_addr_high,
  input  logic [ADDR_W-1:0]     in_source_addr_low,
  input  logic [HANDLE_W-1:0]   in_conn_handle,
  input  cmd_t                  cmd,
  output stat_t                 st,
  output logic                  out_valid,
  output logic [STAT_W-1:0]     out_status,
  output logic [CNT_W-1:0]      out_source_count,
  output logic [CNT_W-1:0]      out_total_count
);

  localparam logic [CNT_W-1:0] MAX_CONN_C = CNT_W'(MAX_CONN);
  localparam logic [CNT_W-1:0] ONE_C      = CNT_W'(1);

  // Control registers.
  logic [CNT_W-1:0] max_total_r, max_total_nxt;
  logic [CNT_W-1:0] max_ps_r, max_ps_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] entries_r, entries_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Working registers of the current beat.
  logic                func_r, func_nxt;
  logic [ADDR_W-1:0]   hi_r, hi_nxt;
  logic [ADDR_W-1:0]   lo_r, lo_nxt;
  logic [HANDLE_W-1:0] h_r, h_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    j_r, j_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt;
  logic [CNT_W-1:0]    num_r, num_nxt;
  logic                found_r, found_nxt;
  status_t             code_r, code_nxt;
  logic [STAT_W-1:0]   res_stat_r, res_stat_nxt;
  logic [CNT_W-1:0]    res_src_r, res_src_nxt;
  logic [CNT_W-1:0]    res_tot_r, res_tot_nxt;

  // Table ports.
  logic              src_we, conn_we;
  logic [IDX_W-1:0]  src_waddr, conn_waddr, src_raddr, conn_raddr;
  logic [SRC_W-1:0]  src_wdata, src_rdata;
  logic [CONN_W-1:0] conn_wdata, conn_rdata;

  // Effective limits.
  logic [CNT_W-1:0] eff_total, eff_ps;
  logic [CNT_W-1:0] num_dec;
  logic [IDX_W-1:0] total_last, entries_last;

  assign eff_total = (max_total_r == '0) ? ONE_C :
                     ((max_total_r > MAX_CONN_C) ? MAX_CONN_C : max_total_r);
  assign eff_ps    = (max_ps_r > eff_total) ? eff_total : max_ps_r;
  assign num_dec   = (num_r != '0) ? (num_r - ONE_C) : '0;

  assign total_last   = IDX_W'(total_r - ONE_C);
  assign entries_last = IDX_W'(entries_r - ONE_C);

  // Status to the controller.
  always_comb begin
    st.req_func         = in_func;
    st.func             = func_r;
    st.src_end          = (idx_r >= entries_r);
    st.src_match        = (src_rdata[SRC_W-1 -: ADDR_W] == hi_r) &&
                          (src_rdata[CNT_W +: ADDR_W] == lo_r);
    st.conn_end         = (idx_r >= total_r);
    st.conn_match       = (conn_rdata[CONN_W-1 -: HANDLE_W] == h_r);
    st.full             = (total_r >= eff_total);
    st.per_src          = (num_r >= eff_ps);
    st.src_found        = found_r;
    st.last_conn_of_src = (num_r <= ONE_C);
  end

  // Read addresses: scan index, or the last occupied entry for a move.
  assign src_raddr  = cmd.src_rd_last  ? entries_last : idx_r[IDX_W-1:0];
  assign conn_raddr = cmd.conn_rd_last ? total_last   : idx_r[IDX_W-1:0];

  // Source table write port.
  always_comb begin
    src_we    = 1'b0;
    src_waddr = j_r;
    src_wdata = {hi_r, lo_r, num_r + ONE_C};
    if (cmd.open_allow) begin
      src_we    = 1'b1;
      src_waddr = found_r ? j_r : entries_r[IDX_W-1:0];
    end else if (cmd.src_dec) begin
      src_we    = 1'b1;
      src_wdata = {hi_r, lo_r, num_dec};
    end else if (cmd.src_move) begin
      src_we    = 1'b1;
      src_wdata = src_rdata;
    end
  end

  // Connection table write port.
  always_comb begin
    conn_we    = 1'b0;
    conn_waddr = total_r[IDX_W-1:0];
    conn_wdata = {h_r, hi_r, lo_r};
    if (cmd.open_allow) begin
      conn_we = 1'b1;
    end else if (cmd.conn_move) begin
      conn_we    = 1'b1;
      conn_waddr = i_r;
      conn_wdata = conn_rdata;
    end
  end

  // Next values of all registers.
  always_comb begin
    max_total_nxt = max_total_r;
    max_ps_nxt    = max_ps_r;
    total_nxt     = total_r;
    entries_nxt   = entries_r;
    out_valid_nxt = cmd.res_load;
    func_nxt      = func_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    h_nxt         = h_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    num_nxt       = num_r;
    found_nxt     = found_r;
    code_nxt      = code_r;
    res_stat_nxt  = res_stat_r;
    res_src_nxt   = res_src_r;
    res_tot_nxt   = res_tot_r;

    // Configuration writes; unknown indexes are ignored.
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_TOTAL:   max_total_nxt = cfg_wdata;
        CFG_MAX_PER_SRC: max_ps_nxt    = cfg_wdata;
        default: ;
      endcase
    end

    // Latch the request beat.
    if (cmd.load) begin
      func_nxt  = in_func;
      hi_nxt    = in_source_addr_high;
      lo_nxt    = in_source_addr_low;
      h_nxt     = in_conn_handle;
      num_nxt   = '0;
      found_nxt = 1'b0;
    end

    // Scan index.
    if (cmd.load || cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + ONE_C;
    end

    // Search hits.
    if (cmd.src_hit) begin
      j_nxt     = idx_r[IDX_W-1:0];
      num_nxt   = src_rdata[CNT_W-1:0];
      found_nxt = 1'b1;
    end
    if (cmd.conn_hit) begin
      i_nxt  = idx_r[IDX_W-1:0];
      hi_nxt = conn_rdata[2*ADDR_W-1 -: ADDR_W];
      lo_nxt = conn_rdata[ADDR_W-1:0];
    end

    // Table bookkeeping.
    if (cmd.open_allow) begin
      num_nxt   = num_r + ONE_C;
      total_nxt = total_r + ONE_C;
      if (!found_r) begin
        entries_nxt = entries_r + ONE_C;
      end
    end
    if (cmd.total_dec) begin
      total_nxt = total_r - ONE_C;
    end
    if (cmd.src_dec) begin
      num_nxt = num_dec;
    end
    if (cmd.src_move) begin
      entries_nxt = entries_r - ONE_C;
    end

    if (cmd.set_code) begin
      code_nxt = cmd.code;
    end

    // Result registers.
    if (cmd.res_load) begin
      res_stat_nxt = code_r;
      res_src_nxt  = num_r;
      res_tot_nxt  = total_r;
    end
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_total_r <= MAX_TOTAL_RST;
      max_ps_r    <= MAX_PER_SRC_RST;
      total_r     <= '0;
      entries_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      max_total_r <= max_total_nxt;
      max_ps_r    <= max_ps_nxt;
      total_r     <= total_nxt;
      entries_r   <= entries_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    h_r        <= h_nxt;
    idx_r      <= idx_nxt;
    j_r        <= j_nxt;
    i_r        <= i_nxt;
    num_r      <= num_nxt;
    found_r    <= found_nxt;
    code_r     <= code_nxt;
    res_stat_r <= res_stat_nxt;
    res_src_r  <= res_src_nxt;
    res_tot_r  <= res_tot_nxt;
  end

  // Source table: address and count per source.
  psl_ram #(
    .WIDTH (SRC_W),
    .DEPTH (MAX_CONN)
  ) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata (src_wdata),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  // Connection table: handle and address per open connection.
  psl_ram #(
    .WIDTH (CONN_W),
    .DEPTH (MAX_CONN)
  ) u_conn_ram (
    .clk   (clk),
    .we    (conn_we),
    .waddr (conn_waddr),
    .wdata (conn_wdata),
    .raddr (conn_raddr),
    .rdata (conn_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = res_stat_r;
  assign out_source_count = res_src_r;
  assign out_total_count  = res_tot_r;

endmodule

[src/per_source_connection_limiter_unit.sv]
// Top level of the per-source connection limiter.
// Joins the controller psl_ctrl and the datapath psl_dp. Depends on psl_pkg.
//
// Usage: a request beat is taken when start is high and busy is low. An open
// request (in_func 0) carries the source address and handle; a close request
// (in_func 1) carries only the handle. Each request gives exactly one result
// beat, shown on out_status, out_source_count and out_total_count while
// out_valid is high for a single cycle; the receiver cannot stall it.
// Limits are written on the cfg_ port (index 0 total limit, index 1
// per-source limit) while the block is idle; other indexes are ignored.
// Only one request is worked on at a time. The tables are scanned linearly
// through a single registered read port each: an open scans the source
// entries, a close scans the open connections and then the source entries,
// and a close of an unknown handle scans only the connections. busy falls in
// the cycle that shows the strobe, so the next request may be taken then.
// Reset clears the counters and restores both limits to 40; table contents
// need no clearing, as only occupied entries are ever read.
module per_source_connection_limiter_unit
  import psl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_func,
  input  logic [ADDR_W-1:0]     in_source_addr_high,
  input  logic [ADDR_W-1:0]     in_source_addr_low,
  input  logic [HANDLE_W-1:0]   in_conn_handle,
  output logic                  out_valid,
  output logic [STAT_W-1:0]     out_status,
  output logic [CNT_W-1:0]      out_source_count,
  output logic [CNT_W-1:0]      out_total_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t st;

  // Sequencer.
  psl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // Tables, counters and result registers.
  psl_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_func             (in_func),
    .in_source_addr_high (in_source_addr_high),
    .in_source_addr_low  (in_source_addr_low),
    .in_conn_handle      (in_conn_handle),
    .cmd                 (cmd),
    .st                  (st),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_source_count    (out_source_count),
    .out_total_count     (out_total_count)
  );

endmodule

[tb/sv/psl_outcome_checker.sv]
// Checker for the per-source connection limiter: watches the request, result
// and limit ports, keeps its own copy of the connection and source tables and
// compares every result beat with the outcome it predicts. Depends on psl_pkg.
module psl_outcome_checker
  import psl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_func,
  input  logic [ADDR_W-1:0]     in_source_addr_high,
  input  logic [ADDR_W-1:0]     in_source_addr_low,
  input  logic [HANDLE_W-1:0]   in_conn_handle,
  input  logic                  out_valid,
  input  logic [STAT_W-1:0]     out_status,
  input  logic [CNT_W-1:0]      out_source_count,
  input  logic [CNT_W-1:0]      out_total_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    owed,
  output int                    allowed,
  output int                    denied_src,
  output int                    denied_full,
  output int                    closed,
  output int                    unknown,
  output int                    peak_open
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] src_n;
    logic [CNT_W-1:0] tot_n;
  } outcome_t;

  // Outcomes predicted for accepted requests whose result beat is still due.
  outcome_t owed_outcomes[$];

  // Limit registers as the block should hold them.
  logic [CNT_W-1:0] total_limit;
  logic [CNT_W-1:0] src_limit;

  // Open connections: handle and source address, packed at the front.
  logic [HANDLE_W-1:0] conn_handle_tab [MAX_CONN];
  logic [ADDR_W-1:0]   conn_hi_tab     [MAX_CONN];
  logic [ADDR_W-1:0]   conn_lo_tab     [MAX_CONN];
  int                  open_n;

  // Sources with at least one open connection and their counts.
  logic [ADDR_W-1:0]   src_hi_tab      [MAX_CONN];
  logic [ADDR_W-1:0]   src_lo_tab      [MAX_CONN];
  int                  src_cnt_tab     [MAX_CONN];
  int                  src_n;

  int err_n;
  int tally [5];
  int peak_n;

  task automatic report_mismatch(input string msg);
    err_n++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // A total limit of zero acts as one, and anything above the table depth
  // acts as the depth.
  function automatic int eff_total_limit();
    int t;
    t = int'(total_limit);
    if (t == 0) t = 1;
    if (t > MAX_CONN) t = MAX_CONN;
    return t;
  endfunction

  // The per-source limit never exceeds the effective total limit.
  function automatic int eff_src_limit();
    int p;
    p = int'(src_limit);
    if (p > eff_total_limit()) p = eff_total_limit();
    return p;
  endfunction

  function automatic int find_src(input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo);
    for (int i = 0; i < src_n; i++)
      if (src_hi_tab[i] == hi && src_lo_tab[i] == lo) return i;
    return src_n;
  endfunction

  // The earliest entry with this handle wins when a handle is open twice.
  function automatic int find_conn(input logic [HANDLE_W-1:0] h);
    for (int i = 0; i < open_n; i++)
      if (conn_handle_tab[i] == h) return i;
    return open_n;
  endfunction

  // Applies one request to the table copy and returns the result it causes.
  function automatic outcome_t apply_request(input logic f,
                                             input logic [ADDR_W-1:0] hi,
                                             input logic [ADDR_W-1:0] lo,
                                             input logic [HANDLE_W-1:0] h);
    outcome_t o;
    int       i;
    int       j;
    int       num;
    int       last;
    o.src_n = '0;
    if (f == FUNC_OPEN) begin
      j   = find_src(hi, lo);
      num = (j < src_n) ? src_cnt_tab[j] : 0;
      // The full check comes before the per-source check.
      if (open_n >= eff_total_limit()) begin
        o.status = ST_DENY_FULL;
        o.src_n  = CNT_W'(num);
      end else if (num >= eff_src_limit()) begin
        o.status = ST_DENY_SRC;
        o.src_n  = CNT_W'(num);
      end else begin
        if (j == src_n) begin
          src_hi_tab[j]  = hi;
          src_lo_tab[j]  = lo;
          src_cnt_tab[j] = 0;
          src_n++;
        end
        src_cnt_tab[j]++;
        o.src_n = CNT_W'(src_cnt_tab[j]);
        conn_handle_tab[open_n] = h;
        conn_hi_tab[open_n]     = hi;
        conn_lo_tab[open_n]     = lo;
        open_n++;
        o.status = ST_ALLOW;
      end
    end else begin
      i = find_conn(h);
      if (i == open_n) begin
        o.status = ST_UNKNOWN;
      end else begin
        j = find_src(conn_hi_tab[i], conn_lo_tab[i]);
        if (j < src_n) begin
          if (src_cnt_tab[j] > 0) src_cnt_tab[j]--;
          o.src_n = CNT_W'(src_cnt_tab[j]);
          // A source with no connections left is replaced by the last one.
          if (src_cnt_tab[j] == 0) begin
            last           = src_n - 1;
            src_hi_tab[j]  = src_hi_tab[last];
            src_lo_tab[j]  = src_lo_tab[last];
            src_cnt_tab[j] = src_cnt_tab[last];
            src_n          = last;
          end
        end
        last               = open_n - 1;
        conn_handle_tab[i] = conn_handle_tab[last];
        conn_hi_tab[i]     = conn_hi_tab[last];
        conn_lo_tab[i]     = conn_lo_tab[last];
        open_n             = last;
        o.status           = ST_CLOSED;
      end
    end
    o.tot_n = CNT_W'(open_n);
    return o;
  endfunction

  // Every rising edge: check a result beat first, then take limit writes and
  // request beats into the table copy.
  always @(posedge clk) begin : watch
    outcome_t want;
    if (!rst_n) begin
      total_limit = MAX_TOTAL_RST;
      src_limit   = MAX_PER_SRC_RST;
      open_n      = 0;
      src_n       = 0;
      owed_outcomes.delete();
    end else begin
      if (out_valid) begin
        if (owed_outcomes.size() == 0) begin
          report_mismatch($sformatf("result beat with status %0d while no request is open",
                                    out_status));
        end else begin
          want = owed_outcomes.pop_front();
          tally[int'(want.status)]++;
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", out_status, want.status));
          if (out_source_count !== want.src_n)
            report_mismatch($sformatf("source count %0d, predicted %0d",
                                      out_source_count, want.src_n));
          if (out_total_count !== want.tot_n)
            report_mismatch($sformatf("total count %0d, predicted %0d",
                                      out_total_count, want.tot_n));
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_TOTAL) total_limit = cfg_wdata;
        else if (cfg_index == CFG_MAX_PER_SRC) src_limit = cfg_wdata;
      end
      if (start && !busy)
        owed_outcomes.push_back(apply_request(in_func, in_source_addr_high,
                                              in_source_addr_low, in_conn_handle));
      if (open_n > peak_n) peak_n = open_n;
    end
    mismatches  <= err_n;
    owed        <= owed_outcomes.size();
    allowed     <= tally[int'(ST_ALLOW)];
    denied_src  <= tally[int'(ST_DENY_SRC)];
    denied_full <= tally[int'(ST_DENY_FULL)];
    closed      <= tally[int'(ST_CLOSED)];
    unknown     <= tally[int'(ST_UNKNOWN)];
    peak_open   <= peak_n;
  end

endmodule

[tb/sv/per_source_connection_limiter_unit_test.sv]
// Top of the per-source connection limiter testbench: clock, reset, request
// and limit stimulus, watchdog and verdict. Depends on psl_pkg, the block
// per_source_connection_limiter_unit and the checker psl_outcome_checker.
module per_source_connection_limiter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psl_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RST_CYCLES   = 4;
  localparam int MAX_GAP      = 10;
  localparam int N_PHASES     = 28;
  localparam int PHASE_BEATS  = 50;
  localparam int DRAIN_CYCLES = 300;
  localparam int POOL_HANDLES = 24;
  localparam int POOL_SRCS    = 8;
  localparam int NOISE_PCT    = 15;
  // Even a close with full tables, with the sender's gap and the limit writes
  // of a phase change, keeps the quiet stretch far below this.
  localparam int WATCHDOG_LIMIT = 5000;

  // Indexes that hold no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_func;
  logic [ADDR_W-1:0]     in_source_addr_high;
  logic [ADDR_W-1:0]     in_source_addr_low;
  logic [HANDLE_W-1:0]   in_conn_handle;
  logic                  out_valid;
  logic [STAT_W-1:0]     out_status;
  logic [CNT_W-1:0]      out_source_count;
  logic [CNT_W-1:0]      out_total_count;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int owed;
  int allowed;
  int denied_src;
  int denied_full;
  int closed;
  int unknown;
  int peak_open;

  int beats_sent;
  int settings_used;
  int gap_cap;
  int quiet;

  // Handles and source addresses that requests are drawn from, so that
  // closes find open handles and sources gather several connections.
  logic [HANDLE_W-1:0] handle_pool [POOL_HANDLES];
  logic [ADDR_W-1:0]   src_hi_pool [POOL_SRCS];
  logic [ADDR_W-1:0]   src_lo_pool [POOL_SRCS];

  always #(CLK_PERIOD / 2) clk = ~clk;

  per_source_connection_limiter_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_source_addr_high (in_source_addr_high),
    .in_source_addr_low  (in_source_addr_low),
    .in_conn_handle      (in_conn_handle),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_source_count    (out_source_count),
    .out_total_count     (out_total_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  psl_outcome_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_source_addr_high (in_source_addr_high),
    .in_source_addr_low  (in_source_addr_low),
    .in_conn_handle      (in_conn_handle),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_source_count    (out_source_count),
    .out_total_count     (out_total_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .mismatches          (mismatches),
    .owed                (owed),
    .allowed             (allowed),
    .denied_src          (denied_src),
    .denied_full         (denied_full),
    .closed              (closed),
    .unknown             (unknown),
    .peak_open           (peak_open)
  );

  // Watchdog: ends the run once no beat has moved on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d results outstanding", quiet, owed);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // Presents one request beat after a random gap and returns at the falling
  // edge after it was taken, with start still high. Called at a falling edge.
  task automatic send(input logic f, input logic [ADDR_W-1:0] hi,
                      input logic [ADDR_W-1:0] lo, input logic [HANDLE_W-1:0] h);
    int gap;
    gap = $urandom_range(0, gap_cap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start               = 1'b1;
    in_func             = f;
    in_source_addr_high = hi;
    in_source_addr_low  = lo;
    in_conn_handle      = h;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted result has arrived.
  task automatic settle();
    start = 1'b0;
    while (owed != 0 || busy) @(negedge clk);
  endtask

  // Writes both limits while the block is idle, sometimes also a spare index.
  task automatic set_limits(input logic [CFG_DATA_W-1:0] total,
                            input logic [CFG_DATA_W-1:0] per_src);
    settle();
    cfg_we    = 1'b1;
    cfg_index = CFG_MAX_TOTAL;
    cfg_wdata = total;
    @(negedge clk);
    cfg_index = CFG_MAX_PER_SRC;
    cfg_wdata = per_src;
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      cfg_index = $urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO;
      cfg_wdata = CFG_DATA_W'($urandom);
      @(negedge clk);
    end
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // One random request: mostly opens and closes over the pools, some noise
  // with arbitrary addresses and handles.
  task automatic random_beat(input int open_pct);
    int s;
    if ($urandom_range(0, 99) < NOISE_PCT) begin
      send($urandom_range(0, 1) ? FUNC_CLOSE : FUNC_OPEN, rand_addr(), rand_addr(),
           HANDLE_W'($urandom));
    end else if ($urandom_range(0, 99) < open_pct) begin
      // The first two sources take the larger share so per-source limits bite.
      s = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(0, POOL_SRCS - 1);
      send(FUNC_OPEN, src_hi_pool[s], src_lo_pool[s],
           handle_pool[$urandom_range(0, POOL_HANDLES - 1)]);
    end else begin
      send(FUNC_CLOSE, rand_addr(), rand_addr(),
           handle_pool[$urandom_range(0, POOL_HANDLES - 1)]);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] total;
    logic [CFG_DATA_W-1:0] per_src;
    int                    open_pct;
    logic [ADDR_W-1:0]     shared;

    rst_n               = 1'b0;
    start               = 1'b0;
    in_func             = FUNC_OPEN;
    in_source_addr_high = '0;
    in_source_addr_low  = '0;
    in_conn_handle      = '0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_MAX_TOTAL;
    cfg_wdata           = '0;
    beats_sent          = 0;
    settings_used       = 0;
    gap_cap             = MAX_GAP;

    // Pools: extreme handles and addresses, and source pairs that agree in
    // one half of the address only.
    handle_pool[0] = '0;
    handle_pool[1] = '1;
    for (int i = 2; i < POOL_HANDLES; i++) handle_pool[i] = HANDLE_W'($urandom);
    for (int i = 0; i < POOL_SRCS; i++) begin
      src_hi_pool[i] = rand_addr();
      src_lo_pool[i] = rand_addr();
    end
    src_hi_pool[0] = '0;
    src_lo_pool[0] = '0;
    src_hi_pool[1] = '1;
    src_lo_pool[1] = '1;
    shared         = rand_addr();
    src_hi_pool[2] = shared;
    src_hi_pool[3] = shared;
    src_lo_pool[5] = src_lo_pool[4];

    repeat (RST_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed beats at the reset limits: close on an empty table, extreme
    // fields, a handle opened twice and closed earliest first.
    send(FUNC_CLOSE, '0, '0, '0);
    send(FUNC_OPEN, '0, '0, '0);
    send(FUNC_OPEN, '1, '1, '1);
    send(FUNC_OPEN, '1, '1, '0);
    send(FUNC_CLOSE, '1, '1, '0);
    send(FUNC_CLOSE, '0, '0, '0);
    send(FUNC_CLOSE, '0, '0, '1);
    send(FUNC_CLOSE, '1, '1, '1);

    // Total limit of zero acting as one; per-source limit of zero denies all.
    set_limits('0, '0);
    send(FUNC_OPEN, src_hi_pool[2], src_lo_pool[2], handle_pool[2]);
    // Per-source limit clipped to the total; then both limits reached at once.
    set_limits('0, CFG_DATA_W'(2));
    send(FUNC_OPEN, src_hi_pool[2], src_lo_pool[2], handle_pool[2]);
    send(FUNC_OPEN, src_hi_pool[2], src_lo_pool[2], handle_pool[3]);
    send(FUNC_OPEN, src_hi_pool[3], src_lo_pool[3], handle_pool[3]);
    // Both limits above the table depth.
    set_limits('1, '1);
    send(FUNC_OPEN, src_hi_pool[3], src_lo_pool[3], handle_pool[3]);
    send(FUNC_OPEN, src_hi_pool[4], src_lo_pool[4], handle_pool[4]);
    send(FUNC_OPEN, src_hi_pool[5], src_lo_pool[5], handle_pool[5]);
    send(FUNC_CLOSE, '0, '0, handle_pool[2]);
    send(FUNC_CLOSE, '1, '1, handle_pool[4]);

    // Random phases, each with its own limits, open share and idling. The
    // tables carry over, so limits are often lowered under open connections.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin total = CFG_DATA_W'(MAX_CONN); per_src = '1; end
        1: begin total = CFG_DATA_W'(MAX_CONN); per_src = CFG_DATA_W'(MAX_CONN); end
        2: begin total = '1; per_src = CFG_DATA_W'(3); end
        3: begin total = CFG_DATA_W'(1); per_src = CFG_DATA_W'(40); end
        4: begin total = '0; per_src = '0; end
        5: begin total = CFG_DATA_W'(MAX_CONN + 1); per_src = CFG_DATA_W'(1); end
        6: begin total = CFG_DATA_W'(MAX_CONN); per_src = '0; end
        7: begin total = CFG_DATA_W'(2); per_src = '1; end
        default: begin
          case ($urandom_range(0, 5))
            0:       total = '0;
            1:       total = '1;
            2:       total = CFG_DATA_W'(MAX_CONN);
            default: total = CFG_DATA_W'($urandom_range(1, MAX_CONN));
          endcase
          case ($urandom_range(0, 5))
            0:       per_src = '0;
            1:       per_src = '1;
            2:       per_src = CFG_DATA_W'($urandom_range(MAX_CONN + 1, 126));
            3:       per_src = CFG_DATA_W'($urandom_range(1, MAX_CONN));
            default: per_src = CFG_DATA_W'($urandom_range(1, 8));
          endcase
        end
      endcase
      set_limits(total, per_src);
      case ($urandom_range(0, 3))
        0:       open_pct = 30;
        1:       open_pct = 50;
        2:       open_pct = 65;
        default: open_pct = 80;
      endcase
      if (ph < 2) open_pct = 85;
      gap_cap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      for (int n = 0; n < PHASE_BEATS; n++) random_beat(open_pct);
    end

    // Drain: wait for the last results, then a little longer for strays.
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d requests under %0d limit settings; at most %0d connections open.",
             beats_sent, settings_used, peak_open);
    $display("Outcomes: %0d allowed, %0d denied per source, %0d denied full, %0d closed, %0d unknown.",
             allowed, denied_src, denied_full, closed, unknown);
    if (mismatches == 0 && owed == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
